FILE: design/sgs_pkg.sv
// shared constants, register map and sine table for the sine gait servo core
// no dependencies; used by sgs_sine_rom and sine_gait_servo_position_step_core
package sgs_pkg;

  // geometry of the sine table and the encoder
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int TICKS_PER_TURN   = 1024;
  localparam int SINE_W           = $clog2(SINE_TABLE_DEPTH);
  localparam int TURN_W           = $clog2(TICKS_PER_TURN);
  localparam int QUARTER_W        = SINE_W - 2;
  localparam int QUARTER_DEPTH    = SINE_TABLE_DEPTH / 4;

  // fixed field widths
  localparam int TIME_W    = 32;
  localparam int STEP_W    = 32;
  localparam int AMP_W     = 11;
  localparam int SHIFT_W   = 10;
  localparam int ZDIR_W    = 10;
  localparam int CZERO_W   = 10;
  localparam int LIMIT_W   = 9;
  localparam int POS_W     = 10;
  localparam int DRIVE_W   = 10;
  localparam int SINE_Q_W  = 16;
  localparam int PROD_W    = AMP_W + 1 + SINE_Q_W;
  localparam int CMD_W     = 30;

  // stream word widths, padded to whole bytes
  localparam int S_DATA_W = ((TIME_W + POS_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((DRIVE_W + POS_W + 7) / 8) * 8;

  // register map, one 32-bit word per register
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_SHIFT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_OFFSET = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MECH_ZERO     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_REVERSE       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MAX_DRIVE     = 3'd6;

  // register reset values
  localparam logic [STEP_W-1:0]  RST_PHASE_STEP = 32'd429497;
  localparam logic [AMP_W-1:0]   RST_AMPLITUDE  = 11'd300;
  localparam logic [LIMIT_W-1:0] RST_MAX_DRIVE  = 9'd200;

  // fixed-point constants of the series
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q15_MAX     = 64'd32767;

  typedef logic [QUARTER_DEPTH-1:0][SINE_Q_W-1:0] quarter_tbl_t;

  // magnitude of sine at quarter-wave step m (0..QUARTER_DEPTH), Q15
  // taylor series to 9th order, horner form, truncating products
  function automatic logic [SINE_Q_W-1:0] sine_mag(input int unsigned m);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    r  = 64'(m) << (30 - QUARTER_W);
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    q  = (s * Q15_MAX + (64'd1 << 29)) >> 30;
    if (q > Q15_MAX) begin
      q = Q15_MAX;
    end
    return q[SINE_Q_W-1:0];
  endfunction

  // first quarter of the wave, steps 0..QUARTER_DEPTH-1
  function automatic quarter_tbl_t build_quarter();
    quarter_tbl_t tbl;
    for (int i = 0; i < QUARTER_DEPTH; i++) begin
      tbl[i] = sine_mag(i);
    end
    return tbl;
  endfunction

  localparam quarter_tbl_t SINE_QUARTER = build_quarter();
  // value at the quarter point itself, reached only from mirrored quadrants
  localparam logic [SINE_Q_W-1:0] SINE_PEAK = sine_mag(QUARTER_DEPTH);

endpackage

FILE: design/sine_gait_servo_position_step_core.sv
// sine trajectory servo step: phase, sine lookup, command, wrapped error, clamp
// every stage is registered from input word to output word; one word per cycle sustained while m_tready holds
// stages: phase multiply, sine lookup, amplitude multiply, command, error and clamp
// a full output stage stalls only as far back as the pipeline holds no bubble
// reset clears all stage valid bits and loads the register reset values
// depends on sgs_pkg and sgs_sine_rom
module sine_gait_servo_position_step_core (
  input  logic                          clk,
  input  logic                          rst,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sgs_pkg::S_DATA_W-1:0]  s_tdata,  // time_ms[31:0], encoder_pos[41:32]
  // output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sgs_pkg::M_DATA_W-1:0]  m_tdata,  // drive[9:0], position_echo[19:10]
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sgs_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // configuration registers
  logic [sgs_pkg::STEP_W-1:0]         phase_step;
  logic [sgs_pkg::AMP_W-1:0]          amplitude;
  logic [sgs_pkg::SHIFT_W-1:0]        phase_shift;
  logic signed [sgs_pkg::ZDIR_W-1:0]  center_offset;
  logic [sgs_pkg::CZERO_W-1:0]        mech_zero;
  logic                               reverse_rotation;
  logic [sgs_pkg::LIMIT_W-1:0]        max_drive;

  logic                               cfg_wr;
  logic [sgs_pkg::REG_IDX_W-1:0]      reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[sgs_pkg::ADDR_W-1 -: sgs_pkg::REG_IDX_W];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step       <= sgs_pkg::RST_PHASE_STEP;
      amplitude        <= sgs_pkg::RST_AMPLITUDE;
      phase_shift      <= '0;
      center_offset    <= '0;
      mech_zero        <= '0;
      reverse_rotation <= 1'b0;
      max_drive        <= sgs_pkg::RST_MAX_DRIVE;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sgs_pkg::REG_PHASE_STEP:    phase_step       <= pwdata[sgs_pkg::STEP_W-1:0];
        sgs_pkg::REG_AMPLITUDE:     amplitude        <= pwdata[sgs_pkg::AMP_W-1:0];
        sgs_pkg::REG_PHASE_SHIFT:   phase_shift      <= pwdata[sgs_pkg::SHIFT_W-1:0];
        sgs_pkg::REG_CENTER_OFFSET: center_offset    <= $signed(pwdata[sgs_pkg::ZDIR_W-1:0]);
        sgs_pkg::REG_MECH_ZERO:     mech_zero        <= pwdata[sgs_pkg::CZERO_W-1:0];
        sgs_pkg::REG_REVERSE:       reverse_rotation <= pwdata[0];
        sgs_pkg::REG_MAX_DRIVE:     max_drive        <= pwdata[sgs_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      sgs_pkg::REG_PHASE_STEP:    prdata = phase_step;
      sgs_pkg::REG_AMPLITUDE:     prdata = 32'(amplitude);
      sgs_pkg::REG_PHASE_SHIFT:   prdata = 32'(phase_shift);
      sgs_pkg::REG_CENTER_OFFSET: prdata = 32'($unsigned(center_offset));
      sgs_pkg::REG_MECH_ZERO:     prdata = 32'(mech_zero);
      sgs_pkg::REG_REVERSE:       prdata = 32'(reverse_rotation);
      sgs_pkg::REG_MAX_DRIVE:     prdata = 32'(max_drive);
      default:                    prdata = '0;
    endcase
  end

  // input word fields
  logic [sgs_pkg::TIME_W-1:0] in_time_ms;
  logic [sgs_pkg::POS_W-1:0]  in_pos;
  assign in_time_ms = s_tdata[sgs_pkg::TIME_W-1:0];
  assign in_pos     = s_tdata[sgs_pkg::TIME_W +: sgs_pkg::POS_W];

  // stage valid bits and per-stage ready
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5 || m_tready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // stage 1: phase as low word of time times step
  logic [sgs_pkg::STEP_W-1:0] phase_next;
  logic [sgs_pkg::STEP_W-1:0] phase1;
  logic [sgs_pkg::POS_W-1:0]  pos1;

  assign phase_next = in_time_ms * phase_step;

  always_ff @(posedge clk) begin
    if (rdy1 && s_tvalid) begin
      phase1 <= phase_next;
      pos1   <= in_pos;
    end
  end

  // stage 2: add joint offset and look up the sine
  logic [sgs_pkg::STEP_W-1:0]          total;
  logic signed [sgs_pkg::SINE_Q_W-1:0] sine_next;
  logic signed [sgs_pkg::SINE_Q_W-1:0] sine2;
  logic [sgs_pkg::POS_W-1:0]           pos2;

  assign total = phase1 + {phase_shift, {(sgs_pkg::STEP_W - sgs_pkg::TURN_W){1'b0}}};

  sgs_sine_rom u_sine_rom (
    .idx  (total[sgs_pkg::STEP_W-1 -: sgs_pkg::SINE_W]),
    .sine (sine_next)
  );

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      sine2 <= sine_next;
      pos2  <= pos1;
    end
  end

  // stage 3: scale by amplitude, Q16 command offset
  logic signed [sgs_pkg::PROD_W-1:0] prod_next;
  logic signed [sgs_pkg::PROD_W-1:0] prod3;
  logic [sgs_pkg::POS_W-1:0]         pos3;

  assign prod_next = $signed({1'b0, amplitude}) * sine2;

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      prod3 <= prod_next;
      pos3  <= pos2;
    end
  end

  // stage 4: command in Q16, truncate toward zero to whole ticks
  logic signed [sgs_pkg::CMD_W-1:0] sum;
  logic signed [sgs_pkg::CMD_W-1:0] signed_sum;
  logic signed [sgs_pkg::CMD_W-1:0] cmd;
  logic [sgs_pkg::TURN_W-1:0]       desired_next;
  logic [sgs_pkg::TURN_W-1:0]       desired4;
  logic [sgs_pkg::POS_W-1:0]        pos4;

  assign sum = $signed({{(sgs_pkg::CMD_W - sgs_pkg::ZDIR_W - 16)
                          {center_offset[sgs_pkg::ZDIR_W-1]}},
                        center_offset, 16'b0})
             + $signed({{(sgs_pkg::CMD_W - sgs_pkg::PROD_W){prod3[sgs_pkg::PROD_W-1]}}, prod3});
  assign signed_sum = reverse_rotation ? -sum : sum;
  assign cmd = signed_sum
             - $signed({{(sgs_pkg::CMD_W - sgs_pkg::CZERO_W - 16){1'b0}}, mech_zero, 16'b0});
  // floor, plus one for a negative value with a fraction
  assign desired_next = cmd[16 +: sgs_pkg::TURN_W]
                      + sgs_pkg::TURN_W'(cmd[sgs_pkg::CMD_W-1] && (cmd[15:0] != '0));

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      desired4 <= desired_next;
      pos4     <= pos3;
    end
  end

  // stage 5: shortest-path error, saturate to max drive
  logic signed [sgs_pkg::TURN_W-1:0]  err;
  logic signed [sgs_pkg::TURN_W:0]    err_x;
  logic signed [sgs_pkg::TURN_W:0]    lim;
  logic signed [sgs_pkg::DRIVE_W-1:0] drive_next;
  logic [sgs_pkg::DRIVE_W-1:0]        drive5;
  logic [sgs_pkg::POS_W-1:0]          pos5;

  // modulo one turn is the low bits; signed view gives the wrap to half a turn
  assign err   = $signed(desired4 - pos4);
  assign err_x = {err[sgs_pkg::TURN_W-1], err};
  assign lim   = $signed({{(sgs_pkg::TURN_W + 1 - sgs_pkg::LIMIT_W){1'b0}}, max_drive});

  always_comb begin
    if (err_x > lim) begin
      drive_next = lim[sgs_pkg::DRIVE_W-1:0];
    end else if (err_x < -lim) begin
      drive_next = sgs_pkg::DRIVE_W'(-lim);
    end else begin
      drive_next = err;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      drive5 <= drive_next;
      pos5   <= pos4;
    end
  end

  // output word
  assign m_tvalid = v5;
  assign m_tdata  = {{(sgs_pkg::M_DATA_W - sgs_pkg::DRIVE_W - sgs_pkg::POS_W){1'b0}},
                     pos5, drive5};

  // checks
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !(v1 || v2 || v3 || v4 || v5))
    else $error("pipeline not empty after reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v1)
    else $error("accepted word did not enter stage 1");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v3 && !rdy3 |=> v3 && $stable(prod3) && $stable(pos3))
    else $error("stalled stage 3 changed");

  a_sine_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> sine2 != $signed({1'b1, {(sgs_pkg::SINE_Q_W-1){1'b0}}}))
    else $error("sine lookup out of Q1.15 range");

endmodule

FILE: design/sgs_sine_rom.sv
// full-wave Q1.15 sine lookup built from the quarter-wave table
// depends on sgs_pkg for the table and widths
module sgs_sine_rom (
  input  logic [sgs_pkg::SINE_W-1:0]          idx,
  output logic signed [sgs_pkg::SINE_Q_W-1:0] sine
);

  logic [1:0]                      quad;
  logic [sgs_pkg::QUARTER_W-1:0]   low;
  logic [sgs_pkg::QUARTER_W-1:0]   mirrored;
  logic                            at_peak;
  logic [sgs_pkg::SINE_Q_W-1:0]    mag;

  // quadrant split, odd quadrants read the table backwards
  assign quad     = idx[sgs_pkg::SINE_W-1 -: 2];
  assign low      = idx[sgs_pkg::QUARTER_W-1:0];
  assign mirrored = quad[0] ? (~low + 1'b1) : low;
  assign at_peak  = quad[0] && (low == '0);

  always_comb begin
    if (at_peak) begin
      mag = sgs_pkg::SINE_PEAK;
    end else begin
      mag = sgs_pkg::SINE_QUARTER[mirrored];
    end
  end

  // lower half of the wave is negative
  assign sine = quad[1] ? -$signed(mag) : $signed(mag);

endmodule

FILE: tb/servo_drive_checker.sv
`timescale 1ns / 1ps
// checker for the sine gait servo step core: watches the tick, drive and register channels
// keeps its own register copy, predicts every drive word and compares; depends on sgs_pkg
module servo_drive_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [sgs_pkg::S_DATA_W-1:0] s_tdata,   // time_ms[31:0], encoder_pos[41:32]
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [sgs_pkg::M_DATA_W-1:0] m_tdata,   // drive[9:0], position_echo[19:10]
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [sgs_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output int                           errors,
  output int                           pending
);

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic signed [sgs_pkg::DRIVE_W-1:0] drive;
    logic [sgs_pkg::POS_W-1:0]          pos;
  } drive_word_t;

  // register copy
  logic [sgs_pkg::STEP_W-1:0]         reg_step;
  logic [sgs_pkg::AMP_W-1:0]          reg_amp;
  logic [sgs_pkg::SHIFT_W-1:0]        reg_shift;
  logic signed [sgs_pkg::ZDIR_W-1:0]  reg_zdir;
  logic [sgs_pkg::CZERO_W-1:0]        reg_czero;
  logic                               reg_rev;
  logic [sgs_pkg::LIMIT_W-1:0]        reg_limit;

  drive_word_t drive_q[$];
  int          err_count = 0;

  // q15 sine of full-wave table entry idx, series evaluated in unsigned q30
  function automatic int sine_q15_at(input int unsigned idx);
    logic [63:0] ang;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    logic [1:0]  quad;
    ang  = (64'(idx % sgs_pkg::SINE_TABLE_DEPTH) << 32) / 64'(sgs_pkg::SINE_TABLE_DEPTH);
    quad = ang[31:30];
    r    = {34'd0, ang[29:0]};
    // odd quadrants run the quarter wave backwards
    if (quad[0]) begin
      r = (64'd1 << 30) - r;
    end
    x  = (r * sgs_pkg::HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = (64'd1 << 30) - x2 / 64'd72;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    q  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return quad[1] ? -int'(q) : int'(q);
  endfunction

  // drive word for one tick under the current registers
  function automatic drive_word_t predict_drive(input logic [sgs_pkg::TIME_W-1:0] tms,
                                                input logic [sgs_pkg::POS_W-1:0] pos);
    logic [63:0]  prod;
    logic [31:0]  offset;
    logic [31:0]  total;
    int unsigned  idx;
    longint       cmd;
    longint       desired;
    longint       err;
    longint       lim;
    drive_word_t  res;
    prod   = 64'(tms) * 64'(reg_step);
    offset = 32'((64'(reg_shift) << 32) / 64'(sgs_pkg::TICKS_PER_TURN));
    total  = prod[31:0] + offset;
    idx    = int'((64'(total) * 64'(sgs_pkg::SINE_TABLE_DEPTH)) >> 32);
    // command in q16, then truncated toward zero
    cmd = longint'(reg_zdir) * 65536 + longint'(reg_amp) * longint'(sine_q15_at(idx));
    if (reg_rev) begin
      cmd = -cmd;
    end
    cmd     = cmd - longint'(reg_czero) * 65536;
    desired = cmd / 65536;
    // shortest path modulo one turn, then clamp
    err = (desired - longint'(pos)) % sgs_pkg::TICKS_PER_TURN;
    if (err < 0) begin
      err = err + sgs_pkg::TICKS_PER_TURN;
    end
    if (err > (sgs_pkg::TICKS_PER_TURN - 1) / 2) begin
      err = err - sgs_pkg::TICKS_PER_TURN;
    end
    lim = longint'(reg_limit);
    if (err > lim) begin
      err = lim;
    end
    if (err < -lim) begin
      err = -lim;
    end
    res.drive = sgs_pkg::DRIVE_W'(err);
    res.pos   = pos;
    return res;
  endfunction

  always @(posedge clk) begin
    drive_word_t got;
    drive_word_t want;
    if (rst) begin
      reg_step  = sgs_pkg::RST_PHASE_STEP;
      reg_amp   = sgs_pkg::RST_AMPLITUDE;
      reg_shift = '0;
      reg_zdir  = '0;
      reg_czero = '0;
      reg_rev   = 1'b0;
      reg_limit = sgs_pkg::RST_MAX_DRIVE;
      drive_q.delete();
    end else begin
      // compare a delivered drive word with the oldest prediction
      if (m_tvalid && m_tready) begin
        got.drive = m_tdata[sgs_pkg::DRIVE_W-1:0];
        got.pos   = m_tdata[sgs_pkg::DRIVE_W +: sgs_pkg::POS_W];
        if (drive_q.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("%0t: drive word with none expected: expected none, actual %h",
                     $time, m_tdata);
          end
        end else begin
          want = drive_q.pop_front();
          if (want.drive !== got.drive) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
              $display("%0t: drive mismatch: expected %0d, actual %0d",
                       $time, want.drive, got.drive);
            end
          end
          if (want.pos !== got.pos) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
              $display("%0t: position echo mismatch: expected %0d, actual %0d",
                       $time, want.pos, got.pos);
            end
          end
        end
      end
      // predict each accepted tick
      if (s_tvalid && s_tready) begin
        drive_q.push_back(predict_drive(s_tdata[sgs_pkg::TIME_W-1:0],
                                        s_tdata[sgs_pkg::TIME_W +: sgs_pkg::POS_W]));
      end
      // register writes, unmapped indexes ignored
      if (psel && penable && pwrite && pready) begin
        case (paddr[sgs_pkg::ADDR_W-1:2])
          sgs_pkg::REG_PHASE_STEP:    reg_step  = pwdata[sgs_pkg::STEP_W-1:0];
          sgs_pkg::REG_AMPLITUDE:     reg_amp   = pwdata[sgs_pkg::AMP_W-1:0];
          sgs_pkg::REG_PHASE_SHIFT:   reg_shift = pwdata[sgs_pkg::SHIFT_W-1:0];
          sgs_pkg::REG_CENTER_OFFSET: reg_zdir  = pwdata[sgs_pkg::ZDIR_W-1:0];
          sgs_pkg::REG_MECH_ZERO:     reg_czero = pwdata[sgs_pkg::CZERO_W-1:0];
          sgs_pkg::REG_REVERSE:       reg_rev   = pwdata[0];
          sgs_pkg::REG_MAX_DRIVE:     reg_limit = pwdata[sgs_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
    errors  <= err_count;
    pending <= int'(drive_q.size());
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// top of the sine gait servo step testbench: clock, reset, register writes and tick traffic
// depends on sgs_pkg, sine_gait_servo_position_step_core and servo_drive_checker
module tb_top;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_TICKS  = 130;
  localparam logic [sgs_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_t;

  logic                         clk;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [sgs_pkg::S_DATA_W-1:0] s_tdata;
  logic                         m_tvalid;
  logic                         m_tready;
  logic [sgs_pkg::M_DATA_W-1:0] m_tdata;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [sgs_pkg::ADDR_W-1:0]   paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;

  int          errors;
  int          pending;
  int          cycle_count = 0;
  int          burst_left  = 0;
  bit          gaps_on     = 1'b1;
  bit          hold_req    = 1'b0;
  bit          hold_active = 1'b0;
  logic [31:0] seq_time;

  sine_gait_servo_position_step_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  servo_drive_checker drive_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .errors   (errors),
    .pending  (pending)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: stall patterns in segments, plus one long hold-off on request
  initial begin
    rx_mode_t mode;
    int       len;
    logic     rdy;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) begin
          m_tready <= 1'b0;
          @(posedge clk);
        end
        hold_active = 1'b0;
      end else begin
        mode = rx_mode_t'($urandom_range(0, 3));
        len  = $urandom_range(1, 40);
        repeat (len) begin
          case (mode)
            RX_OPEN:   rdy = 1'b1;
            RX_COIN:   rdy = 1'($urandom_range(0, 1));
            RX_MOSTLY: rdy = ($urandom_range(0, 7) != 0);
            default:   rdy = ($urandom_range(0, 7) == 0);
          endcase
          m_tready <= rdy;
          @(posedge clk);
        end
      end
    end
  end

  // random bits above a register's width, which the block drops
  function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
    logic [31:0] mask;
    mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
    return ($urandom() & ~mask) | (value & mask);
  endfunction

  // one register write; psel stays up across back-to-back writes
  task automatic write_reg(input logic [sgs_pkg::REG_IDX_W-1:0] idx, input logic [31:0] data,
                           input bit last);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (last) begin
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  task automatic write_all(input logic [sgs_pkg::STEP_W-1:0] step,
                           input logic [sgs_pkg::AMP_W-1:0] amp,
                           input logic [sgs_pkg::SHIFT_W-1:0] shift,
                           input logic [sgs_pkg::ZDIR_W-1:0] zdir,
                           input logic [sgs_pkg::CZERO_W-1:0] czero, input logic rev,
                           input logic [sgs_pkg::LIMIT_W-1:0] limit);
    write_reg(sgs_pkg::REG_PHASE_STEP, step, 1'b0);
    write_reg(sgs_pkg::REG_AMPLITUDE, with_junk(32'(amp), sgs_pkg::AMP_W), 1'b0);
    write_reg(sgs_pkg::REG_PHASE_SHIFT, with_junk(32'(shift), sgs_pkg::SHIFT_W), 1'b0);
    write_reg(sgs_pkg::REG_CENTER_OFFSET, with_junk(32'(zdir), sgs_pkg::ZDIR_W), 1'b0);
    write_reg(sgs_pkg::REG_MECH_ZERO, with_junk(32'(czero), sgs_pkg::CZERO_W), 1'b0);
    write_reg(sgs_pkg::REG_REVERSE, with_junk(32'(rev), 1), 1'b0);
    write_reg(sgs_pkg::REG_MAX_DRIVE, with_junk(32'(limit), sgs_pkg::LIMIT_W), 1'b1);
  endtask

  task automatic random_config();
    logic [sgs_pkg::STEP_W-1:0] step;
    logic [sgs_pkg::AMP_W-1:0]  amp;
    case ($urandom_range(0, 3))
      0:       step = $urandom();
      1:       step = $urandom_range(0, 32'h000F_FFFF);
      2:       step = sgs_pkg::RST_PHASE_STEP + $urandom_range(0, 4000000);
      default: step = 32'hFFFF_FFFF - $urandom_range(0, 1023);
    endcase
    case ($urandom_range(0, 3))
      0:       amp = 11'd2047;
      1:       amp = sgs_pkg::AMP_W'($urandom_range(0, 40));
      default: amp = sgs_pkg::AMP_W'($urandom_range(0, 2047));
    endcase
    write_all(step, amp, sgs_pkg::SHIFT_W'($urandom_range(0, 1023)),
              sgs_pkg::ZDIR_W'($urandom_range(0, 1023)),
              sgs_pkg::CZERO_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
              sgs_pkg::LIMIT_W'($urandom_range(0, 511)));
  endtask

  // offer one tick word; bursts of random length with random gaps between
  task automatic send_tick(input logic [sgs_pkg::TIME_W-1:0] t,
                           input logic [sgs_pkg::POS_W-1:0] p);
    logic [sgs_pkg::S_DATA_W-1:0] word;
    word                                     = '0;
    word[sgs_pkg::TIME_W-1:0]                = t;
    word[sgs_pkg::TIME_W +: sgs_pkg::POS_W]  = p;
    if (gaps_on && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 24);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    s_tdata  <= word;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic stop_stream();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // random ticks: either free-running times or a slowly advancing clock
  task automatic run_ticks(input int n, input bit sequential);
    logic [sgs_pkg::TIME_W-1:0] t;
    logic [sgs_pkg::POS_W-1:0]  p;
    repeat (n) begin
      if (sequential) begin
        t        = seq_time;
        seq_time = seq_time + $urandom_range(1, 40);
      end else begin
        t = $urandom();
      end
      case ($urandom_range(0, 9))
        0:       p = '0;
        1:       p = '1;
        default: p = sgs_pkg::POS_W'($urandom_range(0, 1023));
      endcase
      send_tick(t, p);
    end
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values, time and position extremes
    send_tick(32'd0, 10'd0);
    send_tick(32'hFFFF_FFFF, 10'd1023);
    send_tick(32'd2500, 10'd512);
    send_tick(32'd5000, 10'd511);
    send_tick(32'd7500, 10'd1);
    send_tick(32'h8000_0000, 10'd300);
    stop_stream();
    wait_drained();

    // unmapped register index leaves the map untouched
    write_reg(REG_UNUSED, $urandom(), 1'b1);
    send_tick(32'd2500, 10'd0);
    stop_stream();
    wait_drained();

    // every register at its top, product wraps
    write_all(32'hFFFF_FFFF, 11'd2047, 10'd1023, 10'd511, 10'd1023, 1'b1, 9'd511);
    send_tick(32'hFFFF_FFFF, 10'd0);
    send_tick(32'd1, 10'd1023);
    send_tick(32'd0, 10'd512);
    send_tick(32'h4000_0000, 10'd700);
    stop_stream();
    wait_drained();

    // every register at its bottom, most negative center offset, zero limit
    write_all(32'd0, 11'd0, 10'd0, 10'h200, 10'd0, 1'b0, 9'd0);
    send_tick(32'h1234_5678, 10'd0);
    send_tick(32'hFFFF_FFFF, 10'd1023);
    send_tick(32'd0, 10'd511);
    stop_stream();
    wait_drained();

    // flat command at zero: error wraps onto the shortest path around the half turn
    write_all(32'd0, 11'd0, 10'd0, 10'd0, 10'd0, 1'b0, 9'd511);
    send_tick(32'd0, 10'd0);
    send_tick(32'd0, 10'd511);
    send_tick(32'd0, 10'd512);
    send_tick(32'd0, 10'd513);
    send_tick(32'd0, 10'd1023);
    stop_stream();
    wait_drained();

    // reversed small amplitude: fractional negative command truncates toward zero
    write_all(32'h0100_0000, 11'd3, 10'd0, 10'd0, 10'd0, 1'b1, 9'd511);
    send_tick(32'd64, 10'd0);
    send_tick(32'd192, 10'd0);
    send_tick(32'd32, 10'd0);
    stop_stream();
    wait_drained();

    // random phases, each under its own register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        write_all(32'hFFFF_FFFF, 11'd2047, 10'd1023, 10'd511, 10'd1023, 1'b1, 9'd511);
      end else if (ph == 1) begin
        write_all(32'd0, 11'd0, 10'd0, 10'h200, 10'd0, 1'b0, 9'd0);
      end else begin
        random_config();
      end
      seq_time = $urandom();
      if (ph == 2) begin
        // long receiver hold-off while ticks keep coming without gaps
        hold_req = 1'b1;
        while (!hold_active) @(posedge clk);
        gaps_on = 1'b0;
        run_ticks(100, 1'b0);
        gaps_on = 1'b1;
        run_ticks(PHASE_TICKS - 100, 1'b1);
      end else if (ph == 5) begin
        // sender stops until the pipeline has fully drained
        run_ticks(PHASE_TICKS / 2, 1'b1);
        stop_stream();
        wait_drained();
        run_ticks(PHASE_TICKS / 2, 1'b0);
      end else begin
        run_ticks(PHASE_TICKS, 1'($urandom_range(0, 1)));
      end
      stop_stream();
      wait_drained();
    end

    // let any stray word show up
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
